// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on the rising edge, muted for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// shared widths, constants, sequencer phases and control structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int ANGLE_W   = 32;
    localparam int TIME_W    = 24;
    localparam int RADIUS_W  = 20;
    localparam int BASE_W    = 22;
    localparam int CFG_W     = 22;
    localparam int POS_W     = 48;
    localparam int VEL_W     = 32;
    localparam int WIDE_W    = 64;
    localparam int MULB_W    = 32;
    localparam int DIVISOR_W = 24;
    localparam int TRIG_W    = 34;
    localparam int TRIG_OUT_W = 32;

    localparam logic [0:0] CFG_RADIUS = 1'b0;
    localparam logic [0:0] CFG_BASE   = 1'b1;

    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 20'd33000;
    localparam logic [BASE_W-1:0]    BASE_RESET   = 22'd160000;
    localparam logic [DIVISOR_W-1:0] DIST_DIVISOR = 24'd2000000;
    localparam logic [MULB_W-1:0]    YAW_SCALE    = 32'd683565276;
    localparam logic [MULB_W-1:0]    VEL_SCALE    = 32'd1000000;

    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] Q30_POS   = 34'sd1073741824;
    localparam logic signed [TRIG_W-1:0] Q30_NEG   = -34'sd1073741824;

    localparam logic signed [WIDE_W-1:0] RATE_LIMIT = 64'sd4398046511104;
    localparam logic signed [WIDE_W-1:0] VEL_MAX    = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] VEL_MIN    = -64'sd2147483648;

    typedef enum logic [6:0] {
        PH_DIST = 7'b0000001,
        PH_TURN = 7'b0000010,
        PH_YAW  = 7'b0000100,
        PH_X    = 7'b0001000,
        PH_Y    = 7'b0010000,
        PH_LIN  = 7'b0100000,
        PH_ANG  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   mul_start;
        logic   div_start;
        logic   trig_start;
        logic   write;
        logic   out_load;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic trig_busy;
        logic dt_zero;
    } t_status;

    function automatic logic [TRIG_W-1:0] atan_entry(input logic [4:0] idx);
        logic [TRIG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'd536870912;
            5'd1:  v = 34'd316933406;
            5'd2:  v = 34'd167458907;
            5'd3:  v = 34'd85004756;
            5'd4:  v = 34'd42667331;
            5'd5:  v = 34'd21354465;
            5'd6:  v = 34'd10679838;
            5'd7:  v = 34'd5340245;
            5'd8:  v = 34'd2670163;
            5'd9:  v = 34'd1335087;
            5'd10: v = 34'd667544;
            5'd11: v = 34'd333772;
            5'd12: v = 34'd166886;
            5'd13: v = 34'd83443;
            5'd14: v = 34'd41722;
            5'd15: v = 34'd20861;
            5'd16: v = 34'd10430;
            5'd17: v = 34'd5215;
            5'd18: v = 34'd2608;
            5'd19: v = 34'd1304;
            5'd20: v = 34'd652;
            5'd21: v = 34'd326;
            5'd22: v = 34'd163;
            5'd23: v = 34'd81;
            5'd24: v = 34'd41;
            5'd25: v = 34'd20;
            5'd26: v = 34'd10;
            5'd27: v = 34'd5;
            5'd28: v = 34'd3;
            5'd29: v = 34'd1;
            5'd30: v = 34'd1;
            5'd31: v = 34'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ddo_div.sv =====
// ----------------------------------------------------------------------------
// ddo_div
// radix-2 restoring divider, signed dividend, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ddo_pkg::WIDE_W-1:0]    i_dividend,
    input  logic [ddo_pkg::DIVISOR_W-1:0]        i_divisor,
    output logic                                 o_busy,
    output logic signed [ddo_pkg::WIDE_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(ddo_pkg::WIDE_W);

    logic                               r_busy;
    logic [CNT_W-1:0]                   r_cnt;
    logic [ddo_pkg::WIDE_W-1:0]         r_q;
    logic [ddo_pkg::DIVISOR_W-1:0]      r_rem;
    logic [ddo_pkg::DIVISOR_W-1:0]      r_div;
    logic                               r_neg;
    logic [ddo_pkg::DIVISOR_W:0]        trial;
    logic [ddo_pkg::DIVISOR_W:0]        diff;
    logic                               ge;
    logic [ddo_pkg::DIVISOR_W-1:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_q[ddo_pkg::WIDE_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[ddo_pkg::DIVISOR_W-1:0] : trial[ddo_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ddo_pkg::WIDE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[ddo_pkg::WIDE_W-1] ? -i_dividend : i_dividend;
            r_neg <= i_dividend[ddo_pkg::WIDE_W-1];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[ddo_pkg::WIDE_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -signed'(r_q) : signed'(r_q);

endmodule

// ===== rtl/ddo_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer: steps the datapath through the phases of an odometry update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  ddo_pkg::t_status  i_status,
    output ddo_pkg::t_cmd     o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MSTART = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_DSTART = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_WRITE  = 9'b000100000,
        S_TSTART = 9'b001000000,
        S_TRIG   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    ddo_pkg::t_phase  r_phase, n_phase;
    logic             r_out_valid;
    logic             needs_div;
    logic             out_free;

    assign needs_div = (r_phase == ddo_pkg::PH_DIST) || (r_phase == ddo_pkg::PH_TURN) ||
                       (r_phase == ddo_pkg::PH_LIN)  || (r_phase == ddo_pkg::PH_ANG);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '{load: 1'b0, mul_start: 1'b0, div_start: 1'b0, trig_start: 1'b0,
                    write: 1'b0, out_load: 1'b0, phase: r_phase};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = ddo_pkg::PH_DIST;
                    n_state    = S_MSTART;
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                if (!i_status.mul_busy) begin
                    n_state = needs_div ? S_DSTART : S_WRITE;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                unique case (r_phase)
                    ddo_pkg::PH_DIST: begin
                        n_phase = ddo_pkg::PH_TURN;
                        n_state = S_MSTART;
                    end
                    ddo_pkg::PH_TURN: begin
                        n_phase = ddo_pkg::PH_YAW;
                        n_state = S_MSTART;
                    end
                    ddo_pkg::PH_YAW: begin
                        n_state = S_TSTART;
                    end
                    ddo_pkg::PH_X: begin
                        n_phase = ddo_pkg::PH_Y;
                        n_state = S_MSTART;
                    end
                    ddo_pkg::PH_Y: begin
                        n_phase = ddo_pkg::PH_LIN;
                        n_state = i_status.dt_zero ? S_OUT : S_MSTART;
                    end
                    ddo_pkg::PH_LIN: begin
                        n_phase = ddo_pkg::PH_ANG;
                        n_state = S_MSTART;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_TSTART: begin
                o_cmd.trig_start = 1'b1;
                n_state          = S_TRIG;
            end
            S_TRIG: begin
                if (!i_status.trig_busy) begin
                    n_phase = ddo_pkg::PH_X;
                    n_state = S_MSTART;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= ddo_pkg::PH_DIST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/ddo_dpath.sv =====
// ----------------------------------------------------------------------------
// ddo_dpath
// odometry datapath: serial multiplier, shared divider, cordic and state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_dpath #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]    i_left_angle,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]    i_right_angle,
    input  logic [ddo_pkg::TIME_W-1:0]            i_elapsed_us,
    input  ddo_pkg::t_cmd                         i_cmd,
    output ddo_pkg::t_status                      o_status,
    output logic signed [ddo_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [ddo_pkg::POS_W-1:0]      o_pos_y,
    output logic [ddo_pkg::ANGLE_W-1:0]           o_heading,
    output logic signed [ddo_pkg::VEL_W-1:0]      o_linear_velocity,
    output logic signed [ddo_pkg::VEL_W-1:0]      o_angular_velocity,
    output logic                                  o_zero_time_flag,
    output logic                                  o_position_saturated
);

    localparam int MCNT_W = $clog2(ddo_pkg::MULB_W);
    localparam int TCNT_W = $clog2(TRIG_ITERATIONS);
    localparam int SUM_W  = ddo_pkg::POS_W + 1;

    // configuration
    logic [ddo_pkg::RADIUS_W-1:0]           r_radius;
    logic [ddo_pkg::BASE_W-1:0]             r_base;

    // odometry state
    logic [ddo_pkg::ANGLE_W-1:0]            r_prev_left, r_prev_right, r_yaw;
    logic signed [ddo_pkg::POS_W-1:0]       r_x, r_y;

    // per-sample working registers
    logic signed [ddo_pkg::ANGLE_W-1:0]     r_dl, r_dr;
    logic [ddo_pkg::TIME_W-1:0]             r_dt;
    logic                                   r_dt_zero, r_hit;
    logic signed [ddo_pkg::WIDE_W-1:0]      r_dist, r_turn;
    logic signed [ddo_pkg::VEL_W-1:0]       r_lin, r_ang;

    // serial multiplier
    logic [ddo_pkg::WIDE_W-1:0]             r_ma;
    logic [ddo_pkg::MULB_W-1:0]             r_mb;
    logic signed [ddo_pkg::WIDE_W-1:0]      r_mprod;
    logic [MCNT_W-1:0]                      r_mcnt;
    logic                                   r_mbusy;

    // cordic
    logic signed [ddo_pkg::TRIG_W-1:0]      r_tx, r_ty, r_tz;
    logic [1:0]                             r_quad;
    logic [TCNT_W-1:0]                      r_tcnt;
    logic                                   r_tbusy;
    logic signed [ddo_pkg::TRIG_OUT_W-1:0]  r_cos, r_sin;

    logic signed [ddo_pkg::ANGLE_W:0]       sum_lr, diff_rl;
    logic [ddo_pkg::WIDE_W-1:0]             mul_a;
    logic [ddo_pkg::MULB_W-1:0]             mul_b;
    logic [ddo_pkg::DIVISOR_W-1:0]          divisor;
    logic                                   div_busy;
    logic signed [ddo_pkg::WIDE_W-1:0]      quotient;
    logic [ddo_pkg::ANGLE_W-1:0]            yaw_off;
    logic [ddo_pkg::ANGLE_W-1:0]            z_start;
    logic signed [ddo_pkg::TRIG_W-1:0]      x_sh, y_sh, at;
    logic signed [ddo_pkg::TRIG_W-1:0]      c_raw, s_raw;
    logic signed [ddo_pkg::WIDE_W-1:0]      pos_step;
    logic signed [SUM_W-1:0]                pos_sum;
    logic                                   pos_ovf;
    logic signed [ddo_pkg::POS_W-1:0]       pos_new;
    logic signed [ddo_pkg::WIDE_W-1:0]      rate_v;
    logic signed [ddo_pkg::VEL_W-1:0]       rate_q;

    function automatic logic signed [ddo_pkg::TRIG_OUT_W-1:0] clamp_q30(
        input logic signed [ddo_pkg::TRIG_W-1:0] v
    );
        logic signed [ddo_pkg::TRIG_OUT_W-1:0] r;
        if (v > ddo_pkg::Q30_POS) begin
            r = ddo_pkg::TRIG_OUT_W'(ddo_pkg::Q30_POS);
        end else if (v < ddo_pkg::Q30_NEG) begin
            r = ddo_pkg::TRIG_OUT_W'(ddo_pkg::Q30_NEG);
        end else begin
            r = v[ddo_pkg::TRIG_OUT_W-1:0];
        end
        return r;
    endfunction

    // operand selection
    always_comb begin
        sum_lr  = (ddo_pkg::ANGLE_W+1)'(r_dl) + (ddo_pkg::ANGLE_W+1)'(r_dr);
        diff_rl = (ddo_pkg::ANGLE_W+1)'(r_dr) - (ddo_pkg::ANGLE_W+1)'(r_dl);
        mul_a   = '0;
        mul_b   = '0;
        divisor = '0;
        unique case (i_cmd.phase)
            ddo_pkg::PH_DIST: begin
                mul_a   = ddo_pkg::WIDE_W'(sum_lr);
                mul_b   = ddo_pkg::MULB_W'(r_radius);
                divisor = ddo_pkg::DIST_DIVISOR;
            end
            ddo_pkg::PH_TURN: begin
                mul_a   = ddo_pkg::WIDE_W'(diff_rl);
                mul_b   = ddo_pkg::MULB_W'(r_radius);
                divisor = (r_base == '0) ? ddo_pkg::DIVISOR_W'(1)
                                         : ddo_pkg::DIVISOR_W'(r_base);
            end
            ddo_pkg::PH_YAW: begin
                mul_a = r_turn;
                mul_b = ddo_pkg::YAW_SCALE;
            end
            ddo_pkg::PH_X: begin
                mul_a = r_cos[ddo_pkg::TRIG_OUT_W-1] ? -r_dist : r_dist;
                mul_b = r_cos[ddo_pkg::TRIG_OUT_W-1] ? ddo_pkg::MULB_W'(-r_cos)
                                                      : ddo_pkg::MULB_W'(r_cos);
            end
            ddo_pkg::PH_Y: begin
                mul_a = r_sin[ddo_pkg::TRIG_OUT_W-1] ? -r_dist : r_dist;
                mul_b = r_sin[ddo_pkg::TRIG_OUT_W-1] ? ddo_pkg::MULB_W'(-r_sin)
                                                      : ddo_pkg::MULB_W'(r_sin);
            end
            ddo_pkg::PH_LIN: begin
                mul_a   = r_dist;
                mul_b   = ddo_pkg::VEL_SCALE;
                divisor = r_dt;
            end
            ddo_pkg::PH_ANG: begin
                mul_a   = r_turn;
                mul_b   = ddo_pkg::VEL_SCALE;
                divisor = r_dt;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= ddo_pkg::RADIUS_RESET;
            r_base   <= ddo_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ddo_pkg::CFG_RADIUS: r_radius <= i_cfg_data[ddo_pkg::RADIUS_W-1:0];
                ddo_pkg::CFG_BASE:   r_base   <= i_cfg_data[ddo_pkg::BASE_W-1:0];
            endcase
        end
    end

    // shift-add multiplier, product modulo 2^64
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
            r_mcnt  <= '0;
        end else if (r_mbusy) begin
            r_mcnt <= r_mcnt + 1'b1;
            if (r_mcnt == MCNT_W'(ddo_pkg::MULB_W - 1)) begin
                r_mbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma    <= mul_a;
            r_mb    <= mul_b;
            r_mprod <= '0;
        end else if (r_mbusy) begin
            if (r_mb[0]) begin
                r_mprod <= r_mprod + signed'(r_ma);
            end
            r_ma <= {r_ma[ddo_pkg::WIDE_W-2:0], 1'b0};
            r_mb <= {1'b0, r_mb[ddo_pkg::MULB_W-1:1]};
        end
    end

    ddo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_mprod),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // cordic rotation
    always_comb begin
        yaw_off = r_yaw + 32'h2000_0000;
        z_start = r_yaw - {yaw_off[ddo_pkg::ANGLE_W-1 -: 2], 30'd0};
        x_sh    = r_tx >>> r_tcnt;
        y_sh    = r_ty >>> r_tcnt;
        at      = signed'(ddo_pkg::atan_entry(5'(r_tcnt)));
        unique case (r_quad)
            2'd0: begin
                c_raw = r_tx;
                s_raw = r_ty;
            end
            2'd1: begin
                c_raw = -r_ty;
                s_raw = r_tx;
            end
            2'd2: begin
                c_raw = -r_tx;
                s_raw = -r_ty;
            end
            2'd3: begin
                c_raw = r_ty;
                s_raw = -r_tx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbusy <= 1'b0;
            r_tcnt  <= '0;
        end else if (i_cmd.trig_start) begin
            r_tbusy <= 1'b1;
            r_tcnt  <= '0;
        end else if (r_tbusy) begin
            r_tcnt <= r_tcnt + 1'b1;
            if (r_tcnt == TCNT_W'(TRIG_ITERATIONS - 1)) begin
                r_tbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig_start) begin
            r_quad <= yaw_off[ddo_pkg::ANGLE_W-1 -: 2];
            r_tx   <= ddo_pkg::CORDIC_X0;
            r_ty   <= '0;
            r_tz   <= ddo_pkg::TRIG_W'(signed'(z_start));
        end else if (r_tbusy) begin
            if (!r_tz[ddo_pkg::TRIG_W-1]) begin
                r_tx <= r_tx - y_sh;
                r_ty <= r_ty + x_sh;
                r_tz <= r_tz - at;
            end else begin
                r_tx <= r_tx + y_sh;
                r_ty <= r_ty - x_sh;
                r_tz <= r_tz + at;
            end
        end
        if (!r_tbusy) begin
            r_cos <= clamp_q30(c_raw);
            r_sin <= clamp_q30(s_raw);
        end
    end

    // position accumulate and velocity clamp
    always_comb begin
        pos_step = r_mprod >>> 30;
        pos_sum  = SUM_W'((i_cmd.phase == ddo_pkg::PH_X) ? r_x : r_y) + SUM_W'(pos_step);
        pos_ovf  = pos_sum[SUM_W-1] ^ pos_sum[SUM_W-2];
        if (pos_ovf) begin
            pos_new = pos_sum[SUM_W-1] ? {1'b1, {(ddo_pkg::POS_W-1){1'b0}}}
                                       : {1'b0, {(ddo_pkg::POS_W-1){1'b1}}};
        end else begin
            pos_new = pos_sum[ddo_pkg::POS_W-1:0];
        end

        rate_v = (i_cmd.phase == ddo_pkg::PH_LIN) ? r_dist : r_turn;
        if (rate_v >= ddo_pkg::RATE_LIMIT) begin
            rate_q = ddo_pkg::VEL_W'(ddo_pkg::VEL_MAX);
        end else if (rate_v <= -ddo_pkg::RATE_LIMIT) begin
            rate_q = ddo_pkg::VEL_W'(ddo_pkg::VEL_MIN);
        end else if (quotient > ddo_pkg::VEL_MAX) begin
            rate_q = ddo_pkg::VEL_W'(ddo_pkg::VEL_MAX);
        end else if (quotient < ddo_pkg::VEL_MIN) begin
            rate_q = ddo_pkg::VEL_W'(ddo_pkg::VEL_MIN);
        end else begin
            rate_q = quotient[ddo_pkg::VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_yaw        <= '0;
            r_x          <= '0;
            r_y          <= '0;
        end else if (i_cmd.load) begin
            r_prev_left  <= i_left_angle;
            r_prev_right <= i_right_angle;
        end else if (i_cmd.write) begin
            unique case (i_cmd.phase)
                ddo_pkg::PH_YAW: r_yaw <= r_yaw + r_mprod[47:16];
                ddo_pkg::PH_X:   r_x   <= pos_new;
                ddo_pkg::PH_Y:   r_y   <= pos_new;
                default: begin
                    r_yaw <= r_yaw;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dl      <= signed'(i_left_angle - r_prev_left);
            r_dr      <= signed'(i_right_angle - r_prev_right);
            r_dt      <= i_elapsed_us;
            r_dt_zero <= (i_elapsed_us == '0);
            r_hit     <= 1'b0;
            r_lin     <= '0;
            r_ang     <= '0;
        end else if (i_cmd.write) begin
            unique case (i_cmd.phase)
                ddo_pkg::PH_DIST: r_dist <= quotient;
                ddo_pkg::PH_TURN: r_turn <= quotient;
                ddo_pkg::PH_X:    r_hit  <= r_hit | pos_ovf;
                ddo_pkg::PH_Y:    r_hit  <= r_hit | pos_ovf;
                ddo_pkg::PH_LIN:  r_lin  <= rate_q;
                ddo_pkg::PH_ANG:  r_ang  <= rate_q;
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_x              <= r_x;
            o_pos_y              <= r_y;
            o_heading            <= r_yaw;
            o_linear_velocity    <= r_lin;
            o_angular_velocity   <= r_ang;
            o_zero_time_flag     <= r_dt_zero;
            o_position_saturated <= r_hit;
        end
    end

    assign o_status = '{mul_busy: r_mbusy, div_busy: div_busy, trig_busy: r_tbusy,
                        dt_zero: r_dt_zero};

endmodule

// ===== rtl/diff_drive_odometry.sv =====
// one sample at a time: the input stalls from transfer until the result is loaded;
// a sample runs the 32-step serial multiplier seven times, the 64-step divider four
// times and the cordic once; at zero elapsed time both velocity phases are skipped,
// each one multiply and one divide
// reset: synchronous active low, clears position, heading, last angles and
// restores wheel radius 33000 um and wheel base 160000 um
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// diff_drive_odometry
// differential drive wheel odometry: heading, position and velocities
// ----------------------------------------------------------------------------

module diff_drive_odometry #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]    i_left_angle,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]    i_right_angle,
    input  logic [ddo_pkg::TIME_W-1:0]            i_elapsed_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ddo_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [ddo_pkg::POS_W-1:0]      o_pos_y,
    output logic [ddo_pkg::ANGLE_W-1:0]           o_heading,
    output logic signed [ddo_pkg::VEL_W-1:0]      o_linear_velocity,
    output logic signed [ddo_pkg::VEL_W-1:0]      o_angular_velocity,
    output logic                                  o_zero_time_flag,
    output logic                                  o_position_saturated
);

    ddo_pkg::t_cmd    cmd;
    ddo_pkg::t_status status;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddo_dpath #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_left_angle         (i_left_angle),
        .i_right_angle        (i_right_angle),
        .i_elapsed_us         (i_elapsed_us),
        .i_cmd                (cmd),
        .o_status             (status),
        .o_pos_x              (o_pos_x),
        .o_pos_y              (o_pos_y),
        .o_heading            (o_heading),
        .o_linear_velocity    (o_linear_velocity),
        .o_angular_velocity   (o_angular_velocity),
        .o_zero_time_flag     (o_zero_time_flag),
        .o_position_saturated (o_position_saturated)
    );

    `ASSERT_CLK(a_busy_after_transfer, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `ASSERT_NEVER(a_zero_time_velocity, i_clk, i_rst_n, o_out_valid && o_zero_time_flag && (o_linear_velocity != 0 || o_angular_velocity != 0))

endmodule
